>>> rtl/core/window_support_rotator_defines.svh
// Assertion helpers shared by the rotator RTL.
// Every macro samples on clk and is muted while rst is high.
`ifndef WINDOW_SUPPORT_ROTATOR_DEFINES_SVH
`define WINDOW_SUPPORT_ROTATOR_DEFINES_SVH

// Same-cycle implication.
`define WSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window_support_rotator: assertion failed");

// Next-cycle implication.
`define WSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window_support_rotator: assertion failed");

`endif

>>> rtl/core/wsr_pkg.sv
`timescale 1ns / 1ps

package wsr_pkg;

  localparam int WORD_BITS = 32;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_GEOM = 2'd1;
  localparam status_t STAT_GAP  = 2'd2;

  typedef enum logic [2:0] {
    REG_WORD_WIDTH    = 3'd0,
    REG_WINDOW_LENGTH = 3'd1,
    REG_SHIFT_AMOUNT  = 3'd2,
    REG_GAP_POSITION  = 3'd3,
    REG_REVERSE_MODE  = 3'd4
  } reg_index_t;

  // Window geometry, derived once from the configuration registers
  typedef struct packed {
    logic       geo_bad;
    logic       gap_bad;
    logic [4:0] lo;
    logic [5:0] rot_main;
    logic [5:0] back_main;
    logic [5:0] rot_blk;
    logic [5:0] back_blk;
    word_t      span_mask;
    word_t      clen_mask;
    word_t      win_mask;
    word_t      pack_mask;
    word_t      gap_mask;
  } geom_t;

  // One word in flight
  typedef struct packed {
    word_t   sup;
    logic    blk;
    status_t status;
    word_t   field;
  } stage_t;

endpackage

>>> rtl/core/window_support_rotator.sv
`timescale 1ns / 1ps
// An accepted word moves from stage 1 through stages 2 and 3 to the output register.
// Throughput: one word per cycle; each of the four stages holds one word and
// the stages move independently, so a stall on the result side fills bubbles first.
// Reset (rst, synchronous): clears every stage valid bit and loads the
// configuration defaults (width 28, window 12, shift 12, gap 15, forward mode).

`include "window_support_rotator_defines.svh"

module window_support_rotator (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [5:0]             cfg_data,
  // item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  wsr_pkg::word_t         support,
  input  logic                   is_blocked,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output wsr_pkg::word_t         new_support,
  output logic                   blocked_out,
  output wsr_pkg::status_t       status
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [5:0] word_width;
  logic [4:0] window_length;
  logic [4:0] shift_amount;
  logic [4:0] gap_position;
  logic       reverse_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_width    <= 6'd28;
      window_length <= 5'd12;
      shift_amount  <= 5'd12;
      gap_position  <= 5'd15;
      reverse_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsr_pkg::REG_WORD_WIDTH:    word_width    <= cfg_data;
        wsr_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[4:0];
        wsr_pkg::REG_SHIFT_AMOUNT:  shift_amount  <= cfg_data[4:0];
        wsr_pkg::REG_GAP_POSITION:  gap_position  <= cfg_data[4:0];
        wsr_pkg::REG_REVERSE_MODE:  reverse_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry: masks, offsets and rotation distances. Registered once so that
  // the datapath stages see a clean, settled copy. The first stage to use it
  // sits one register behind the input, so a word accepted straight after a
  // configuration write already sees the new geometry.
  // ---------------------------------------------------------------------------
  wsr_pkg::geom_t geom;
  wsr_pkg::geom_t geom_next;

  logic [6:0] span7;
  logic [5:0] span6;
  logic [6:0] lo_full;
  logic [5:0] hi6;
  logic [5:0] gp6;
  logic [4:0] gap_rel;
  logic [4:0] gap_lo;

  always_comb begin
    span7   = 7'(window_length) + 7'(shift_amount) + 7'd2;
    span6   = span7[5:0];
    lo_full = 7'(word_width) - span7;

    geom_next.geo_bad = (window_length == 5'd0) || (shift_amount == 5'd0) ||
                        (shift_amount > window_length) ||
                        (span7 > 7'(word_width)) ||
                        (word_width > 6'(wsr_pkg::WORD_BITS));

    // Forward mode puts the window at the top of the word, reverse at the bottom
    geom_next.lo = reverse_mode ? 5'd0 : lo_full[4:0];
    hi6          = 6'(geom_next.lo) + span6;

    geom_next.span_mask = wsr_pkg::word_t'((33'd1 << span6) - 33'd1);
    geom_next.clen_mask = geom_next.span_mask >> 2;
    geom_next.win_mask  = geom_next.span_mask << geom_next.lo;

    // Left rotation by r is (x << r) | (x >> (len - r)); hold both distances
    geom_next.rot_main  = reverse_mode ? 6'(window_length) + 6'd2 : 6'(shift_amount);
    geom_next.back_main = reverse_mode ? 6'(shift_amount) : 6'(window_length) + 6'd2;
    geom_next.rot_blk   = reverse_mode ? 6'(window_length) : 6'(shift_amount);
    geom_next.back_blk  = reverse_mode ? 6'(shift_amount) : 6'(window_length);

    gp6 = 6'(gap_position);
    geom_next.gap_bad = (gap_position == 5'd0) ||
                        ((gp6 - 6'd1) < 6'(geom_next.lo)) ||
                        (gp6 >= hi6);

    gap_lo  = gap_position - 5'd1;
    gap_rel = gap_lo - geom_next.lo;
    geom_next.pack_mask = (wsr_pkg::word_t'(1) << gap_rel) - wsr_pkg::word_t'(1);
    geom_next.gap_mask  = wsr_pkg::word_t'(3) << gap_lo;
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage takes a new word when it is empty or its word moves on
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !result_valid || !result_stall;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign item_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) v1           <= item_valid;
      if (rdy2) v2           <= v1;
      if (rdy3) v3           <= v2;
      if (rdy4) result_valid <= v3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the word
  // ---------------------------------------------------------------------------
  wsr_pkg::word_t s1_sup;
  logic           s1_blk;

  always_ff @(posedge clk) begin
    if (rdy1 && item_valid) begin
      s1_sup <= support;
      s1_blk <= is_blocked;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pull the window down to bit 0, drop the two gap bits in blocked
  // mode so the remaining bits close up, and settle the status
  // ---------------------------------------------------------------------------
  wsr_pkg::stage_t s2;
  wsr_pkg::stage_t s2_next;
  wsr_pkg::word_t  win_x;

  always_comb begin
    win_x          = (s1_sup >> geom.lo) & geom.span_mask;
    s2_next.sup    = s1_sup;
    s2_next.blk    = s1_blk;
    priority if (geom.geo_bad) begin
      s2_next.status = wsr_pkg::STAT_GEOM;
    end else if (s1_blk && geom.gap_bad) begin
      s2_next.status = wsr_pkg::STAT_GAP;
    end else begin
      s2_next.status = wsr_pkg::STAT_OK;
    end
    s2_next.field = s1_blk ? ((win_x & geom.pack_mask) | ((win_x >> 2) & ~geom.pack_mask))
                           : win_x;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) s2 <= s2_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: rotate the packed field inside its own length
  // ---------------------------------------------------------------------------
  wsr_pkg::stage_t s3;
  wsr_pkg::stage_t s3_next;
  logic [5:0]      rot_dist;
  logic [5:0]      back_dist;
  wsr_pkg::word_t  len_mask;

  always_comb begin
    rot_dist      = s2.blk ? geom.rot_blk  : geom.rot_main;
    back_dist     = s2.blk ? geom.back_blk : geom.back_main;
    len_mask      = s2.blk ? geom.clen_mask : geom.span_mask;
    s3_next       = s2;
    s3_next.field = ((s2.field << rot_dist) | (s2.field >> back_dist)) & len_mask;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) s3 <= s3_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 4 (output register): open the gap again, lift the window back into
  // place, keep the bits outside it, and pass the word through on any error
  // ---------------------------------------------------------------------------
  wsr_pkg::word_t expanded;
  wsr_pkg::word_t merged;
  wsr_pkg::word_t res_next;

  always_comb begin
    expanded = s3.blk ? ((s3.field & geom.pack_mask) | ((s3.field & ~geom.pack_mask) << 2))
                      : s3.field;
    merged   = (s3.sup & ~geom.win_mask) | ((expanded << geom.lo) & geom.win_mask) |
               (s3.blk ? (s3.sup & geom.gap_mask) : '0);
    res_next = (s3.status == wsr_pkg::STAT_OK) ? merged : s3.sup;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      new_support <= res_next;
      blocked_out <= s3.blk;
      status      <= s3.status;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // A permutation neither makes nor loses set bits
  `WSR_ASSERT_NEXT(a_ones_kept, rdy4 && v3, $countones(new_support) == $past($countones(s3.sup)))
  // Gap bits stay where they are in blocked mode
  `WSR_ASSERT_NEXT(a_gap_fixed, rdy4 && v3 && s3.blk, (new_support & geom.gap_mask) == $past(s3.sup & geom.gap_mask))
  // A gap error only comes from a blocked word
  `WSR_ASSERT_IMPL(a_gap_blk, result_valid && (status == wsr_pkg::STAT_GAP), blocked_out)

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// What one accepted word should come back as
typedef struct {
  wsr_pkg::word_t   sup;
  logic             blk;
  wsr_pkg::status_t status;
} rotated_word_t;

class rotation_scoreboard;
  logic [5:0]    width_q;
  logic [4:0]    window_q;
  logic [4:0]    shift_q;
  logic [4:0]    gap_q;
  logic          reverse_q;
  rotated_word_t outstanding[$];
  int unsigned   checked;
  int unsigned   failures;
  int unsigned   status_seen[3];
  int unsigned   compacted;

  function new();
    width_q   = 6'd28;
    window_q  = 5'd12;
    shift_q   = 5'd12;
    gap_q     = 5'd15;
    reverse_q = 1'b0;
  endfunction

  function void update_reg(logic [2:0] idx, logic [5:0] data);
    case (idx)
      wsr_pkg::REG_WORD_WIDTH:    width_q   = data;
      wsr_pkg::REG_WINDOW_LENGTH: window_q  = data[4:0];
      wsr_pkg::REG_SHIFT_AMOUNT:  shift_q   = data[4:0];
      wsr_pkg::REG_GAP_POSITION:  gap_q     = data[4:0];
      wsr_pkg::REG_REVERSE_MODE:  reverse_q = data[0];
      default: ;
    endcase
  endfunction

  function logic [63:0] low_mask(int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // rotate the low len bits of v left by sh
  function logic [63:0] rotl_field(logic [63:0] v, int unsigned len, int unsigned sh);
    logic [63:0] m;
    m  = low_mask(len);
    v  = v & m;
    sh = sh % len;
    if (sh == 0) return v;
    return ((v << sh) | (v >> (len - sh))) & m;
  endfunction

  function rotated_word_t predict_rotation(wsr_pkg::word_t sup, logic blk);
    rotated_word_t e;
    int unsigned   ww, win, shf, gp, span, lo, hi, clen, sh, cp;
    logic [63:0]   res, wm, squeezed, rotated;
    ww  = width_q;
    win = window_q;
    shf = shift_q;
    gp  = gap_q;
    e.blk    = blk;
    e.status = wsr_pkg::STAT_OK;
    res  = {32'd0, sup};
    span = win + shf + 2;
    if (win < 1 || shf < 1 || shf > win || span > ww || ww > wsr_pkg::WORD_BITS) begin
      e.status = wsr_pkg::STAT_GEOM;
    end else begin
      lo = reverse_q ? 0 : ww - span;
      hi = lo + span;
      if (!blk) begin
        wm  = low_mask(span) << lo;
        sh  = reverse_q ? span - shf : shf;
        res = (res & ~wm) | ((rotl_field((res & wm) >> lo, span, sh) << lo) & wm);
      end else if (gp < 1 || gp - 1 < lo || gp >= hi) begin
        e.status = wsr_pkg::STAT_GAP;
      end else begin
        // squeeze out the two gap bits, rotate, spread back
        clen     = span - 2;
        sh       = reverse_q ? clen - shf : shf;
        squeezed = '0;
        cp       = 0;
        for (int unsigned b = lo; b < hi; b++) begin
          if (b == gp - 1 || b == gp) continue;
          squeezed[cp] = res[b];
          cp++;
        end
        rotated = rotl_field(squeezed, clen, sh);
        cp      = 0;
        for (int unsigned b = lo; b < hi; b++) begin
          if (b == gp - 1 || b == gp) continue;
          res[b] = rotated[cp];
          cp++;
        end
      end
    end
    e.sup = res[31:0];
    return e;
  endfunction

  function void note_word(wsr_pkg::word_t sup, logic blk);
    rotated_word_t e;
    e = predict_rotation(sup, blk);
    status_seen[e.status]++;
    if (blk && e.status == wsr_pkg::STAT_OK) compacted++;
    outstanding.push_back(e);
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH %s", msg);
  endfunction

  function void check_result(wsr_pkg::word_t got_sup, logic got_blk,
                             wsr_pkg::status_t got_status);
    rotated_word_t e;
    if (outstanding.size() == 0) begin
      note_failure($sformatf("unexpected word: new_support %h blocked_out %b status %0d",
                             got_sup, got_blk, got_status));
      return;
    end
    e = outstanding.pop_front();
    checked++;
    if (got_sup !== e.sup || got_blk !== e.blk || got_status !== e.status)
      note_failure($sformatf(
        "word %0d: new_support %h/%h blocked_out %b/%b status %0d/%0d (expected/actual)",
        checked, e.sup, got_sup, e.blk, got_blk, e.status, got_status));
  endfunction
endclass

module tb;
  localparam int unsigned LATENCY         = 4;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned PHASES          = 13;
  localparam int unsigned WORDS_PER_PHASE = 90;
  localparam int unsigned REG_COUNT       = 5;     // indexes from here up are unused
  localparam int unsigned LONG_HOLD       = 300;

  typedef enum int unsigned {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_style_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_we       = 1'b0;
  logic [2:0]       cfg_index    = wsr_pkg::REG_WORD_WIDTH;
  logic [5:0]       cfg_data     = '0;
  logic             item_valid   = 1'b0;
  wsr_pkg::word_t   support      = '0;
  logic             is_blocked   = 1'b0;
  logic             result_stall = 1'b0;
  logic             item_stall;
  logic             result_valid;
  wsr_pkg::word_t   new_support;
  logic             blocked_out;
  wsr_pkg::status_t status;

  rotation_scoreboard sb;
  idle_style_t        send_style   = IDLE_SPARSE;
  idle_style_t        recv_style   = IDLE_SPARSE;
  int unsigned        hold_request = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        settings     = 1;   // the reset settings count as one

  window_support_rotator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .support      (support),
    .is_blocked   (is_blocked),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .new_support  (new_support),
    .blocked_out  (blocked_out),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("window_support_rotator regression: fail");
      $finish;
    end
  end

  // Check every word taken off the result channel against the oldest prediction.
  // Values read here are the ones held up to this edge, so no race with the drivers.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(new_support, blocked_out, status);
  end

  // Idle count for one word; sparse mode leaves most words back to back
  function automatic int unsigned draw_wait(idle_style_t style);
    case (style)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
      default:     return $urandom_range(0, 16);
    endcase
  endfunction

  // Result side: stall a drawn number of cycles before each word, or honour a
  // long hold-off when one is requested so that the pipe backs up to the input.
  initial begin : result_side
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
      end else begin
        hold = draw_wait(recv_style);
      end
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid && hold_request == 0);
    end
  end

  // Offer one word after a drawn idle gap; hold the payload until it is taken.
  // With no gap, valid stays high straight on from the previous word.
  task automatic send_word(input wsr_pkg::word_t sup, input logic blk);
    int unsigned pause;
    pause = draw_wait(send_style);
    if (pause != 0) begin
      item_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    item_valid <= 1'b1;
    support    <= sup;
    is_blocked <= blk;
    do @(posedge clk); while (item_stall);
    sb.note_word(sup, blk);
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (sb.outstanding.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [5:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.update_reg(idx, data);
  endtask

  // Change settings only with the pipe empty. Spare upper data bits are
  // randomised since the narrower registers must ignore them.
  task automatic apply_config(input logic [5:0] ww, input logic [4:0] win,
                              input logic [4:0] sh, input logic [4:0] gap,
                              input logic rev);
    wait_for_results();
    repeat (LATENCY) @(posedge clk);
    write_register(wsr_pkg::REG_WORD_WIDTH, ww);
    write_register(wsr_pkg::REG_WINDOW_LENGTH, {1'($urandom_range(0, 1)), win});
    write_register(wsr_pkg::REG_SHIFT_AMOUNT, {1'($urandom_range(0, 1)), sh});
    write_register(wsr_pkg::REG_GAP_POSITION, {1'($urandom_range(0, 1)), gap});
    write_register(wsr_pkg::REG_REVERSE_MODE, {5'($urandom_range(0, 31)), rev});
    // a write to an unused index must change nothing
    if ($urandom_range(0, 2) == 0)
      write_register(3'($urandom_range(REG_COUNT, 7)), 6'($urandom_range(0, 63)));
    cfg_we <= 1'b0;
    repeat (LATENCY) @(posedge clk);
    settings++;
  endtask

  // Mostly sound geometry with the gap inside the window; now and then anything at all
  task automatic random_config();
    logic [5:0]  ww;
    logic [4:0]  win, sh, gap;
    logic        rev;
    int unsigned span, lo;
    rev = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 5) != 0) begin
      ww   = 6'($urandom_range(4, wsr_pkg::WORD_BITS));
      sh   = 5'($urandom_range(1, (ww - 2) / 2));
      win  = 5'($urandom_range(sh, ww - 2 - sh));
      span = win + sh + 2;
      lo   = rev ? 0 : ww - span;
      if ($urandom_range(0, 4) != 0) gap = 5'($urandom_range(lo + 1, lo + span - 1));
      else gap = 5'($urandom_range(0, 31));
    end else begin
      ww  = 6'($urandom_range(0, 63));
      win = 5'($urandom_range(0, 31));
      sh  = 5'($urandom_range(0, 31));
      gap = 5'($urandom_range(0, 31));
    end
    apply_config(ww, win, sh, gap, rev);
  endtask

  function automatic wsr_pkg::word_t random_support();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return wsr_pkg::word_t'(1) << $urandom_range(0, 31);
      default: return wsr_pkg::word_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: window of 26 bits at the top of a 28-bit word
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b1);
    send_word('1, 1'b1);

    // Span covering the whole 32-bit word, forward
    apply_config(32, 15, 15, 16, 1'b0);
    send_word(32'hFFFF_0001, 1'b0);
    send_word(32'h8000_0001, 1'b1);
    // Full span in reverse, gap pair at the very bottom
    apply_config(32, 15, 15, 1, 1'b1);
    send_word(32'h0000_FFFE, 1'b0);
    send_word(32'h8000_0003, 1'b1);
    // Smallest span; bits above the word width pass through
    apply_config(4, 1, 1, 3, 1'b0);
    send_word(32'hFFFF_FFF1, 1'b0);
    send_word(32'h0000_0005, 1'b1);
    // Longest window, gap pair at the top
    apply_config(32, 29, 1, 31, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h1234_5678, 1'b0);

    // Bad geometry: shift beyond window, width beyond the word, zero window,
    // zero shift, span wider than the width
    apply_config(32, 1, 2, 15, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b0);
    apply_config(63, 31, 29, 31, 1'b1);
    send_word(32'hCAFE_F00D, 1'b1);
    apply_config(28, 0, 12, 15, 1'b0);
    send_word(32'h0F0F_0F0F, 1'b0);
    apply_config(28, 12, 0, 15, 1'b0);
    send_word(32'hF0F0_F0F0, 1'b1);
    apply_config(20, 12, 12, 15, 1'b0);
    send_word(32'h5555_5555, 1'b0);

    // Gap pair outside the window: gap at zero (main mode still rotates),
    // lower gap bit just below the window, upper gap bit just above it
    apply_config(28, 12, 12, 0, 1'b0);
    send_word(32'h0123_4567, 1'b1);
    send_word(32'h0123_4567, 1'b0);
    apply_config(28, 12, 12, 2, 1'b0);
    send_word(32'h89AB_CDEF, 1'b1);
    apply_config(16, 6, 6, 14, 1'b1);
    send_word(32'h0000_3FFF, 1'b1);
    send_word(32'h0000_3FFF, 1'b0);

    // Random phases: fresh settings and idling styles each time
    for (int p = 0; p < PHASES; p++) begin
      random_config();
      send_style = idle_style_t'($urandom_range(0, 2));
      recv_style = idle_style_t'($urandom_range(0, 2));
      if (p == 2) begin
        // long hold-off on the result side while words keep coming back to back
        hold_request = LONG_HOLD;
        send_style   = IDLE_NONE;
      end
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i == WORDS_PER_PHASE / 2 && (p == 4 || $urandom_range(0, 3) == 0))
          wait_for_results();
        send_word(random_support(), 1'($urandom_range(0, 1)));
      end
    end

    wait_for_results();
    repeat (LATENCY * 4) @(posedge clk);

    $display("Checked %0d words across %0d register settings, %0d failures",
             sb.checked, settings, sb.failures);
    $display("Status mix: %0d ok (%0d compacted around the gap), %0d bad geometry, %0d gap outside",
             sb.status_seen[wsr_pkg::STAT_OK], sb.compacted,
             sb.status_seen[wsr_pkg::STAT_GEOM], sb.status_seen[wsr_pkg::STAT_GAP]);
    if (sb.failures == 0) begin
      $display("window_support_rotator regression: pass");
    end else begin
      $display("window_support_rotator regression: fail");
    end
    $finish;
  end
endmodule
